FILE: rtl/hpbi_pkg.sv
// ----------------------------------------------------------------------------
// hpbi_pkg
// Shared types and constants for the half-pel block interpolator.
// ----------------------------------------------------------------------------
package hpbi_pkg;

  // pixel geometry of one row
  localparam int PIX_W   = 8;
  localparam int LANES   = 8;
  localparam int ROW_W   = PIX_W * LANES;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_ROUND_DOWN = 2'd0;

  // interpolation modes
  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_HOR  = 2'd1,
    MODE_VER  = 2'd2,
    MODE_DIAG = 2'd3
  } hpbi_mode_t;

  // result carried from the lanes into the output buffer
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
  } hpbi_result_t;

endpackage

FILE: rtl/hpbi_lane.sv
// ----------------------------------------------------------------------------
// hpbi_lane
// One pixel lane: half-pel average of up to four neighbours, then an
// optional average with the destination pixel.
// ----------------------------------------------------------------------------
module hpbi_lane (
  input  hpbi_pkg::hpbi_mode_t          mode,
  input  logic                          truncate,
  input  logic                          add_dest,
  input  logic [hpbi_pkg::PIX_W-1:0]    cur_pix,
  input  logic [hpbi_pkg::PIX_W-1:0]    cur_right,
  input  logic [hpbi_pkg::PIX_W-1:0]    prev_pix,
  input  logic [hpbi_pkg::PIX_W-1:0]    prev_right,
  input  logic [hpbi_pkg::PIX_W-1:0]    dest_pix,
  output logic [hpbi_pkg::PIX_W-1:0]    pix_out
);

  logic [hpbi_pkg::PIX_W:0]   sum_hor;
  logic [hpbi_pkg::PIX_W:0]   sum_ver;
  logic [hpbi_pkg::PIX_W+1:0] sum_diag;
  logic [hpbi_pkg::PIX_W:0]   sum_dest;
  logic [hpbi_pkg::PIX_W-1:0] pred;
  logic                       bias1;

  // rounding bias, dropped when truncating
  assign bias1 = ~truncate;

  // pairwise and four-way sums
  assign sum_hor  = {1'b0, cur_pix} + {1'b0, cur_right} + {{hpbi_pkg::PIX_W{1'b0}}, bias1};
  assign sum_ver  = {1'b0, cur_pix} + {1'b0, prev_pix} + {{hpbi_pkg::PIX_W{1'b0}}, bias1};
  assign sum_diag = {2'b00, cur_pix} + {2'b00, cur_right} + {2'b00, prev_pix}
                  + {2'b00, prev_right} + {{hpbi_pkg::PIX_W{1'b0}}, bias1, truncate};

  // prediction per mode
  always_comb begin
    case (mode)
      hpbi_pkg::MODE_COPY: pred = cur_pix;
      hpbi_pkg::MODE_HOR:  pred = sum_hor[hpbi_pkg::PIX_W:1];
      hpbi_pkg::MODE_VER:  pred = sum_ver[hpbi_pkg::PIX_W:1];
      hpbi_pkg::MODE_DIAG: pred = sum_diag[hpbi_pkg::PIX_W+1:2];
      default:             pred = cur_pix;
    endcase
  end

  // average with destination, rounding up
  assign sum_dest = {1'b0, pred} + {1'b0, dest_pix} + {{hpbi_pkg::PIX_W{1'b0}}, 1'b1};
  assign pix_out  = add_dest ? sum_dest[hpbi_pkg::PIX_W:1] : pred;

endmodule

FILE: rtl/hpbi_merge.sv
// ----------------------------------------------------------------------------
// hpbi_merge
// Packs the lane pixels into one output row and holds results in a
// two-entry output buffer (head register plus skid register).
// ----------------------------------------------------------------------------
module hpbi_merge (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              push,
  input  logic [hpbi_pkg::LANES-1:0][hpbi_pkg::PIX_W-1:0]   lane_pix,
  input  logic                                              last,
  input  logic                                              out_stall,
  output logic                                              out_valid,
  output hpbi_pkg::hpbi_result_t                            head,
  output logic                                              full
);

  hpbi_pkg::hpbi_result_t new_res;
  hpbi_pkg::hpbi_result_t head_r;
  hpbi_pkg::hpbi_result_t skid_r;
  logic                   head_vld_r;
  logic                   head_vld_nxt;
  logic                   skid_vld_r;
  logic                   skid_vld_nxt;
  logic                   pop;
  logic                   load_head;
  logic                   load_skid;

  // merge the lane results
  assign new_res.row  = lane_pix;
  assign new_res.last = last;

  assign pop = head_vld_r & ~out_stall;

  // buffer occupancy
  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    load_head    = 1'b0;
    load_skid    = 1'b0;
    if (skid_vld_r) begin
      if (pop) begin
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_vld_r || pop) begin
        load_head    = 1'b1;
        head_vld_nxt = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      head_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_head) begin
      head_r <= new_res;
    end else if (skid_vld_r && pop) begin
      head_r <= skid_r;
    end
    if (load_skid) begin
      skid_r <= new_res;
    end
  end

  assign out_valid = head_vld_r;
  assign head      = head_r;
  assign full      = skid_vld_r;

endmodule

FILE: rtl/half_pel_block_interpolator.sv
// ----------------------------------------------------------------------------
// half_pel_block_interpolator
// Half-pel motion-compensation interpolator for blocks of BLOCK_ROWS rows.
// ----------------------------------------------------------------------------
// Takes one source row request per clock while in_stall is low: eight pixel
// lanes compute the row combinationally from the request and the held
// previous row, and a two-entry output buffer registers the result, so the
// sustained rate is one row per cycle while out_stall is low and in_stall
// rises only once two finished rows wait behind a stalled output. Copy and
// horizontal blocks give BLOCK_ROWS outputs; vertical and diagonal blocks
// take BLOCK_ROWS+1 rows and the start row gives none. Rows that arrive after
// a block is complete are dropped until the next start. The user writes
// round_down over the APB port at address 0 while the block is idle; unenforced.
// ----------------------------------------------------------------------------
module half_pel_block_interpolator #(
  parameter int BLOCK_ROWS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // source row requests
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_start_of_block,
  input  logic [1:0]                           in_mode,
  input  logic                                 in_add_to_dest,
  input  logic [hpbi_pkg::ROW_W-1:0]           in_src_row,
  input  logic [hpbi_pkg::PIX_W-1:0]           in_src_extra,
  input  logic [hpbi_pkg::ROW_W-1:0]           in_dest_row,
  // output row requests
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hpbi_pkg::ROW_W-1:0]           out_row,
  output logic                                 out_last_row,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hpbi_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [hpbi_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [hpbi_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int CNT_W = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_ROWS - 1);

  logic                         round_down_r;
  logic [hpbi_pkg::ROW_W-1:0]   prev_row_r;
  logic [hpbi_pkg::PIX_W-1:0]   prev_extra_r;
  logic [CNT_W-1:0]             rows_r;
  logic [CNT_W-1:0]             rows_nxt;
  hpbi_pkg::hpbi_mode_t         mode_r;
  logic                         add_r;
  logic                         done_r;
  logic                         done_nxt;

  logic                         accept;
  logic                         ignore_row;
  logic                         vert_start;
  logic                         produce;
  logic                         is_last;
  logic                         truncate;
  logic                         eff_add;
  hpbi_pkg::hpbi_mode_t         eff_mode;
  logic [CNT_W-1:0]             eff_rows;
  logic [hpbi_pkg::ROW_W-1:0]   cur_sh;
  logic [hpbi_pkg::ROW_W-1:0]   prev_sh;
  logic [hpbi_pkg::LANES-1:0][hpbi_pkg::PIX_W-1:0] lane_pix;
  hpbi_pkg::hpbi_result_t       head;
  logic                         buf_full;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == hpbi_pkg::REG_ROUND_DOWN)
                ? {{(hpbi_pkg::CFG_DATA_W-1){1'b0}}, round_down_r}
                : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_down_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == hpbi_pkg::REG_ROUND_DOWN) begin
      round_down_r <= pwdata[0];
    end
  end

  // block control
  assign accept     = in_valid & ~in_stall;
  assign eff_mode   = in_start_of_block ? hpbi_pkg::hpbi_mode_t'(in_mode) : mode_r;
  assign eff_add    = in_start_of_block ? in_add_to_dest : add_r;
  assign eff_rows   = in_start_of_block ? '0 : rows_r;
  assign ignore_row = ~in_start_of_block & done_r;
  assign vert_start = in_start_of_block & eff_mode[1];
  assign produce    = accept & ~ignore_row & ~vert_start;
  assign is_last    = (eff_rows == LAST_CNT);
  assign truncate   = round_down_r & ~eff_add;

  always_comb begin
    rows_nxt = rows_r;
    done_nxt = done_r;
    if (accept && in_start_of_block) begin
      rows_nxt = '0;
      done_nxt = 1'b0;
    end
    if (produce) begin
      if (is_last) begin
        rows_nxt = '0;
        done_nxt = 1'b1;
      end else begin
        rows_nxt = eff_rows + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r       <= '0;
      done_r       <= 1'b0;
      mode_r       <= hpbi_pkg::MODE_COPY;
      add_r        <= 1'b0;
      prev_row_r   <= '0;
      prev_extra_r <= '0;
    end else begin
      rows_r <= rows_nxt;
      done_r <= done_nxt;
      if (accept && in_start_of_block) begin
        mode_r <= eff_mode;
        add_r  <= in_add_to_dest;
      end
      if (accept && !ignore_row) begin
        prev_row_r   <= in_src_row;
        prev_extra_r <= in_src_extra;
      end
    end
  end

  // right-neighbour rows
  assign cur_sh  = {in_src_extra, in_src_row[hpbi_pkg::ROW_W-1:hpbi_pkg::PIX_W]};
  assign prev_sh = {prev_extra_r, prev_row_r[hpbi_pkg::ROW_W-1:hpbi_pkg::PIX_W]};

  // pixel lanes
  for (genvar k = 0; k < hpbi_pkg::LANES; k++) begin : g_lane
    hpbi_lane u_lane (
      .mode       (eff_mode),
      .truncate   (truncate),
      .add_dest   (eff_add),
      .cur_pix    (in_src_row[k*hpbi_pkg::PIX_W +: hpbi_pkg::PIX_W]),
      .cur_right  (cur_sh[k*hpbi_pkg::PIX_W +: hpbi_pkg::PIX_W]),
      .prev_pix   (prev_row_r[k*hpbi_pkg::PIX_W +: hpbi_pkg::PIX_W]),
      .prev_right (prev_sh[k*hpbi_pkg::PIX_W +: hpbi_pkg::PIX_W]),
      .dest_pix   (in_dest_row[k*hpbi_pkg::PIX_W +: hpbi_pkg::PIX_W]),
      .pix_out    (lane_pix[k])
    );
  end

  // merge and output buffer
  hpbi_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (produce),
    .lane_pix  (lane_pix),
    .last      (is_last),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .full      (buf_full)
  );

  assign in_stall     = buf_full;
  assign out_row      = head.row;
  assign out_last_row = head.last;

endmodule

FILE: rtl/hpbi_checker.sv
// ----------------------------------------------------------------------------
// hpbi_checker
// Port-level checks for the half-pel block interpolator, bound to the top.
// ----------------------------------------------------------------------------
module hpbi_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [hpbi_pkg::ROW_W-1:0]           out_row,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [hpbi_pkg::CFG_ADDR_W-1:0]      paddr,
  input logic [hpbi_pkg::CFG_DATA_W-1:0]      pwdata,
  input logic [hpbi_pkg::CFG_DATA_W-1:0]      prdata
);

  // input stalls only with a result waiting at the output
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a waiting output row");

  // input stall only arises behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without a stalled output");

  // a stalled output request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row))
    else $error("stalled output request changed");

  // written rounding control reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr == hpbi_pkg::REG_ROUND_DOWN
    |=> paddr != hpbi_pkg::REG_ROUND_DOWN || prdata[0] == $past(pwdata[0]))
    else $error("round_down read back differs from write");

endmodule

bind half_pel_block_interpolator hpbi_checker u_hpbi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_row   (out_row),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the half-pel block interpolator: source row
// requests are driven with random gaps, output rows are taken with random
// stalls, and each output row is checked against a row predicted from the
// same requests.
// ----------------------------------------------------------------------------
module tb;

  localparam int BLOCK_ROWS = 8;
  localparam int CYCLE_LIMIT = 200000;

  // predicted output rows, checked in arrival order
  class interp_scoreboard;
    bit round_down;
    logic [hpbi_pkg::ROW_W-1:0] prev_row;
    logic [hpbi_pkg::PIX_W-1:0] prev_extra;
    int rows_given;
    hpbi_pkg::hpbi_mode_t blk_mode;
    bit blk_add;
    bit blk_done;
    hpbi_pkg::hpbi_result_t predicted_rows[$];
    int errors;

    function new();
      round_down = 1'b0;
      prev_row = '0;
      prev_extra = '0;
      rows_given = 0;
      blk_mode = hpbi_pkg::MODE_COPY;
      blk_add = 1'b0;
      blk_done = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return predicted_rows.size();
    endfunction

    // works out the output row, if any, of one accepted request
    function void predict_row(bit start, hpbi_pkg::hpbi_mode_t mode, bit add,
                              logic [hpbi_pkg::ROW_W-1:0] src,
                              logic [hpbi_pkg::PIX_W-1:0] extra,
                              logic [hpbi_pkg::ROW_W-1:0] dest);
      logic [hpbi_pkg::ROW_W-1:0] src_sh;
      logic [hpbi_pkg::ROW_W-1:0] prev_sh;
      logic [hpbi_pkg::ROW_W-1:0] row;
      logic [9:0] a, b, c, d, p;
      bit trunc;
      int k;
      hpbi_pkg::hpbi_result_t res;
      if (start) begin
        blk_mode = mode;
        blk_add = add;
        rows_given = 0;
        blk_done = 1'b0;
      end else if (blk_done) begin
        return;
      end
      // vertical modes only hold the start row
      if (start && blk_mode[1]) begin
        prev_row = src;
        prev_extra = extra;
        return;
      end
      trunc = round_down && !blk_add;
      src_sh = {extra, src[hpbi_pkg::ROW_W-1:hpbi_pkg::PIX_W]};
      prev_sh = {prev_extra, prev_row[hpbi_pkg::ROW_W-1:hpbi_pkg::PIX_W]};
      for (k = 0; k < hpbi_pkg::LANES; k++) begin
        a = {2'b00, src[hpbi_pkg::PIX_W*k +: hpbi_pkg::PIX_W]};
        b = {2'b00, src_sh[hpbi_pkg::PIX_W*k +: hpbi_pkg::PIX_W]};
        c = {2'b00, prev_row[hpbi_pkg::PIX_W*k +: hpbi_pkg::PIX_W]};
        d = {2'b00, prev_sh[hpbi_pkg::PIX_W*k +: hpbi_pkg::PIX_W]};
        case (blk_mode)
          hpbi_pkg::MODE_COPY: p = a;
          hpbi_pkg::MODE_HOR:  p = (a + b + (trunc ? 10'd0 : 10'd1)) >> 1;
          hpbi_pkg::MODE_VER:  p = (c + a + (trunc ? 10'd0 : 10'd1)) >> 1;
          default:             p = (a + b + c + d + (trunc ? 10'd1 : 10'd2)) >> 2;
        endcase
        if (blk_add) p = (p + {2'b00, dest[hpbi_pkg::PIX_W*k +: hpbi_pkg::PIX_W]} + 10'd1) >> 1;
        row[hpbi_pkg::PIX_W*k +: hpbi_pkg::PIX_W] = p[hpbi_pkg::PIX_W-1:0];
      end
      prev_row = src;
      prev_extra = extra;
      rows_given++;
      res.row = row;
      res.last = (rows_given >= BLOCK_ROWS);
      if (res.last) begin
        blk_done = 1'b1;
        rows_given = 0;
      end
      predicted_rows.push_back(res);
    endfunction

    // compares one accepted output row with the oldest prediction
    function void check_row(logic [hpbi_pkg::ROW_W-1:0] row, logic last);
      hpbi_pkg::hpbi_result_t exp_row;
      if (predicted_rows.size() == 0) begin
        $display("%0t: unexpected output row %h last %b", $time, row, last);
        errors++;
        return;
      end
      exp_row = predicted_rows.pop_front();
      if (row !== exp_row.row) begin
        $display("%0t: out_row expected %h actual %h", $time, exp_row.row, row);
        errors++;
      end
      if (last !== exp_row.last) begin
        $display("%0t: out_last_row expected %b actual %b", $time, exp_row.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_start_of_block;
  logic [1:0] in_mode;
  logic in_add_to_dest;
  logic [hpbi_pkg::ROW_W-1:0] in_src_row;
  logic [hpbi_pkg::PIX_W-1:0] in_src_extra;
  logic [hpbi_pkg::ROW_W-1:0] in_dest_row;
  logic out_valid;
  logic out_stall;
  logic [hpbi_pkg::ROW_W-1:0] out_row;
  logic out_last_row;
  logic psel;
  logic penable;
  logic pwrite;
  logic [hpbi_pkg::CFG_ADDR_W-1:0] paddr;
  logic [hpbi_pkg::CFG_DATA_W-1:0] pwdata;
  logic [hpbi_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  interp_scoreboard sb;
  int snd_idle_pct;
  int rcv_stall_pct;
  int cycle_count;

  half_pel_block_interpolator #(.BLOCK_ROWS(BLOCK_ROWS)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_of_block(in_start_of_block),
    .in_mode(in_mode),
    .in_add_to_dest(in_add_to_dest),
    .in_src_row(in_src_row),
    .in_src_extra(in_src_extra),
    .in_dest_row(in_dest_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row(out_row),
    .out_last_row(out_last_row),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  // output row check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_row(out_row, out_last_row);
  end

  // pixel byte, biased towards the extremes
  function automatic logic [hpbi_pkg::PIX_W-1:0] rand_pix();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return hpbi_pkg::PIX_W'($urandom_range(255));
  endfunction

  function automatic logic [hpbi_pkg::ROW_W-1:0] rand_row();
    logic [hpbi_pkg::ROW_W-1:0] row;
    int k;
    for (k = 0; k < hpbi_pkg::LANES; k++) row[hpbi_pkg::PIX_W*k +: hpbi_pkg::PIX_W] = rand_pix();
    return row;
  endfunction

  // one source row request, held until accepted
  task automatic send_row(bit start, hpbi_pkg::hpbi_mode_t mode, bit add,
                          logic [hpbi_pkg::ROW_W-1:0] src,
                          logic [hpbi_pkg::PIX_W-1:0] extra,
                          logic [hpbi_pkg::ROW_W-1:0] dest);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_of_block <= start;
    in_mode <= mode;
    in_add_to_dest <= add;
    in_src_row <= src;
    in_src_extra <= extra;
    in_dest_row <= dest;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_row(start, mode, add, src, extra, dest);
  endtask

  // sender pause until every predicted row has come out
  task automatic drain(int extra_cycles);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_round_down(bit value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= hpbi_pkg::REG_ROUND_DOWN;
    pwdata <= hpbi_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.round_down = value;
    @(posedge clk);
  endtask

  // edge cases of block framing and pixel range
  task automatic directed_rows();
    int i;
    // rows before any start form an open copy block
    send_row(1'b0, hpbi_pkg::MODE_DIAG, 1'b1, {8{8'hFF}}, 8'hFF, {8{8'h00}});
    send_row(1'b0, hpbi_pkg::MODE_HOR, 1'b0, {8{8'h00}}, 8'h00, {8{8'hFF}});
    send_row(1'b0, hpbi_pkg::MODE_COPY, 1'b0, 64'h0123_4567_89AB_CDEF, 8'h5A, rand_row());
    // vertical with add, abandoned after one output
    send_row(1'b1, hpbi_pkg::MODE_VER, 1'b1, {8{8'hFF}}, 8'hFF, {8{8'h00}});
    send_row(1'b0, hpbi_pkg::MODE_VER, 1'b1, {8{8'h00}}, 8'h00, {8{8'hFF}});
    // horizontal at the extremes, abandoned
    send_row(1'b1, hpbi_pkg::MODE_HOR, 1'b0, {8{8'hFF}}, 8'hFF, {8{8'hFF}});
    send_row(1'b0, hpbi_pkg::MODE_HOR, 1'b0, 64'hFF00_FF00_FF00_FF00, 8'h01, {8{8'h00}});
    // diagonal with add, abandoned
    send_row(1'b1, hpbi_pkg::MODE_DIAG, 1'b1, {8{8'hFF}}, 8'hFF, {8{8'hFF}});
    send_row(1'b0, hpbi_pkg::MODE_DIAG, 1'b1, {8{8'h00}}, 8'h00, {8{8'h00}});
    send_row(1'b0, hpbi_pkg::MODE_DIAG, 1'b1, 64'h00FF_00FF_00FF_00FF, 8'hFE, {8{8'hFF}});
    // complete copy block, then rows past its end are dropped
    for (i = 0; i < BLOCK_ROWS + 2; i++)
      send_row(i == 0, hpbi_pkg::MODE_COPY, 1'b0, rand_row(), rand_pix(), rand_row());
  endtask

  // random blocks, mostly well formed
  task automatic random_rows(int n_items);
    int count;
    int kind;
    int n_rows;
    int i;
    hpbi_pkg::hpbi_mode_t mode;
    bit add;
    count = 0;
    while (count < n_items) begin
      kind = $urandom_range(99);
      mode = hpbi_pkg::hpbi_mode_t'($urandom_range(3));
      add = 1'($urandom_range(1));
      if (kind < 80) begin
        n_rows = mode[1] ? BLOCK_ROWS + 1 : BLOCK_ROWS;
        for (i = 0; i < n_rows; i++)
          send_row(i == 0, i == 0 ? mode : hpbi_pkg::hpbi_mode_t'($urandom_range(3)),
                   i == 0 ? add : 1'($urandom_range(1)),
                   rand_row(), rand_pix(), rand_row());
        count += n_rows;
        // trailing rows after a finished block
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(2, 1))
            send_row(1'b0, hpbi_pkg::hpbi_mode_t'($urandom_range(3)),
                     1'($urandom_range(1)), rand_row(), rand_pix(), rand_row());
        end
      end else if (kind < 92) begin
        // block cut short by the next start
        n_rows = $urandom_range(BLOCK_ROWS - 1, 1);
        for (i = 0; i < n_rows; i++)
          send_row(i == 0, mode, add, rand_row(), rand_pix(), rand_row());
        count += n_rows;
      end else begin
        // noise with random start flags
        n_rows = $urandom_range(6, 1);
        for (i = 0; i < n_rows; i++)
          send_row($urandom_range(3) == 0, hpbi_pkg::hpbi_mode_t'($urandom_range(3)),
                   1'($urandom_range(1)), rand_row(), rand_pix(), rand_row());
        count += n_rows;
      end
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    cycle_count = 0;
    snd_idle_pct = 11;
    rcv_stall_pct = 70;
    rst_n <= 1'b0;
    out_stall <= 1'b0;
    in_valid <= 1'b0;
    in_start_of_block <= 1'b0;
    in_mode <= hpbi_pkg::MODE_COPY;
    in_add_to_dest <= 1'b0;
    in_src_row <= '0;
    in_src_extra <= '0;
    in_dest_row <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= hpbi_pkg::REG_ROUND_DOWN;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled
    write_round_down(1'b0);
    directed_rows();
    random_rows(430);
    drain(4);

    // sender mostly idle, receiver mostly ready
    write_round_down(1'b1);
    snd_idle_pct = 70;
    rcv_stall_pct = 11;
    random_rows(230);
    drain(4);
    random_rows(230);
    drain(4);

    // no idling on either side
    write_round_down(1'b0);
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    random_rows(230);
    drain(4);
    write_round_down(1'b1);
    random_rows(230);
    drain(8);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
